FILE: hw/rtl/cae_pkg.sv
package cae_pkg;

	localparam int POS_W      = 32;
	localparam int REG_W      = 16;
	localparam int IDX_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int COEF_FRAC  = 8;
	localparam int STEP_FRAC  = 16;
	localparam int BR_W       = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A    = 3'd0,
		REG_COEF_B    = 3'd1,
		REG_COEF_C    = 3'd2,
		REG_STEP_SIZE = 3'd3,
		REG_X_SCALE   = 3'd4,
		REG_Y_SCALE   = 3'd5,
		REG_X_MIN     = 3'd6,
		REG_Y_MIN     = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MS_HOLD = 3'd0,
		MS_BR1  = 3'd1,
		MS_BR2  = 3'd2,
		MS_BR3  = 3'd3,
		MS_HX   = 3'd4,
		MS_HY   = 3'd5,
		MS_HZ   = 3'd6,
		MS_PIX  = 3'd7
	} mul_sel_t;

	typedef enum logic [2:0] {
		US_NONE = 3'd0,
		US_BR2  = 3'd1,
		US_BR3  = 3'd2,
		US_BR4  = 3'd3,
		US_X    = 3'd4,
		US_Y    = 3'd5,
		US_Z    = 3'd6
	} upd_sel_t;

	typedef struct packed {
		logic     load_point;
		mul_sel_t mul_sel;
		upd_sel_t upd_sel;
		logic     out_load;
	} dp_cmd_t;

endpackage

FILE: hw/rtl/chaotic_attractor_euler_plot.sv
// Channel   Handshake               Payload
// request   req_valid / req_ready   cmd, load_x, load_y, load_z
// result    rsp_valid / rsp_ready   pos_x, pos_y, pos_z, x_index, y_index, clipped
// config    cfg_we                  cfg_index, cfg_data
//
// A step item passes BR1, BR2, BR3, BR4, UX, UY, UZ, PIX and DONE before the next acceptance;
// a load item passes PIX and DONE; the two shared multipliers serve twelve step products and
// two pixel products. The result and rsp_valid are registered together on leaving DONE.
// Reset restores the default registers and the point (0.5, 0.5, 0.5).
// A result waits in the output register; the sequencer holds its last state while it is untaken.
module chaotic_attractor_euler_plot import cae_pkg::*; #(
	parameter int PALETTE_WIDTH  = 1920,
	parameter int PALETTE_HEIGHT = 1080,
	parameter int FRAC_BITS      = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    cmd,
	input  logic signed [POS_W-1:0] load_x,
	input  logic signed [POS_W-1:0] load_y,
	input  logic signed [POS_W-1:0] load_z,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [IDX_W-1:0]        x_index,
	output logic [IDX_W-1:0]        y_index,
	output logic                    clipped,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	dp_cmd_t dp_cmd;

	cae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_cmd    (dp_cmd)
	);

	cae_dp #(
		.PALETTE_WIDTH  (PALETTE_WIDTH),
		.PALETTE_HEIGHT (PALETTE_HEIGHT),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load_x    (load_x),
		.load_y    (load_y),
		.load_z    (load_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.x_index   (x_index),
		.y_index   (y_index),
		.clipped   (clipped)
	);

endmodule

FILE: hw/rtl/cae_mul.sv
module cae_mul #(
	parameter int A_W = 33,
	parameter int B_W = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [A_W-1:0]  a,
	input  logic signed [B_W-1:0]  b,
	output logic signed [A_W+B_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a * b;
		end
	end

endmodule

FILE: hw/rtl/cae_dp.sv
module cae_dp import cae_pkg::*; #(
	parameter int PALETTE_WIDTH  = 1920,
	parameter int PALETTE_HEIGHT = 1080,
	parameter int FRAC_BITS      = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 dp_cmd,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data,
	input  logic signed [POS_W-1:0] load_x,
	input  logic signed [POS_W-1:0] load_y,
	input  logic signed [POS_W-1:0] load_z,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [IDX_W-1:0]        x_index,
	output logic [IDX_W-1:0]        y_index,
	output logic                    clipped
);

	localparam int DIFF_W = ((FRAC_BITS + REG_W > POS_W) ? FRAC_BITS + REG_W : POS_W) + 1;
	localparam int MA_W   = DIFF_W;
	localparam int MB_W   = POS_W + 1;
	localparam int PW     = MA_W + MB_W;
	localparam int XW     = POS_W + 1;
	localparam int CW     = REG_W + 1;
	localparam int ACC_W  = (2 * POS_W - FRAC_BITS + 2 > BR_W + 1) ?
	                        2 * POS_W - FRAC_BITS + 2 : BR_W + 1;
	localparam int SUM_W  = BR_W - STEP_FRAC + REG_W + 3;
	localparam int FS_W   = 2 * REG_W + 1;
	localparam int PIX_SH = FRAC_BITS + COEF_FRAC;

	localparam logic signed [PW-1:0]    HALF_C   = PW'(1) << (COEF_FRAC - 1);
	localparam logic signed [PW-1:0]    HALF_P   = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0]    PIX_HALF = PW'(1) << (PIX_SH - 1);
	localparam logic signed [PW-1:0]    X_LAST   = PW'(PALETTE_WIDTH - 1);
	localparam logic signed [PW-1:0]    Y_LAST   = PW'(PALETTE_HEIGHT - 1);
	localparam logic signed [ACC_W-1:0] BR_MAX   = (ACC_W'(1) << (BR_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] BR_MIN   = ~BR_MAX;
	localparam logic signed [SUM_W-1:0] P_MAX    = (SUM_W'(1) << (POS_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] P_MIN    = ~P_MAX;
	localparam logic [FS_W-1:0]         FS_HALF  = FS_W'(1) << (STEP_FRAC - 1);
	localparam logic signed [POS_W-1:0] POS_INIT = POS_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             clip;
	} pix_t;

	logic signed [REG_W-1:0] coef_a_q, coef_b_q, coef_c_q, x_min_q, y_min_q;
	logic [REG_W-1:0]        step_size_q, x_scale_q, y_scale_q;
	logic signed [POS_W-1:0] point_x_q, point_y_q, point_z_q;
	logic signed [ACC_W-1:0] bx_q, by_q, bz_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [IDX_W-1:0]        x_index_q, y_index_q;
	logic                    clipped_q;

	logic signed [XW-1:0]     d_yx;
	logic signed [CW-1:0]     c_minus_a;
	logic signed [DIFF_W-1:0] x_off, y_off;
	logic signed [ACC_W-1:0]  br_pick;
	logic signed [BR_W-1:0]   br_sat;
	logic signed [MA_W-1:0]   m0_a, m1_a;
	logic signed [MB_W-1:0]   m0_b, m1_b;
	logic                     mul_en;
	logic signed [PW-1:0]     p0, p1;
	logic signed [PW-1:0]     p0_rc_w, p0_rp_w, p1_rc_w;
	logic signed [ACC_W-1:0]  p0_rc, p0_rp, p1_rc;
	logic [FS_W-1:0]          frac_sum;
	logic signed [SUM_W-1:0]  frac_ext, new_sum;
	logic signed [POS_W-1:0]  pos_old, pos_new;
	pix_t                     pix_x, pix_y;

	function automatic logic signed [BR_W-1:0] sat_br(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		if (v > BR_MAX) begin
			t = BR_MAX;
		end else if (v < BR_MIN) begin
			t = BR_MIN;
		end else begin
			t = v;
		end
		sat_br = t[BR_W-1:0];
	endfunction

	// Rounds to nearest with ties away from zero, then clamps to the palette.
	function automatic pix_t pix_map(input logic signed [PW-1:0] v,
		input logic signed [PW-1:0] last);
		logic signed [PW-1:0] r;
		pix_t res;
		r = (v + PIX_HALF - $signed({{(PW-1){1'b0}}, v[PW-1]})) >>> PIX_SH;
		res.clip = 1'b0;
		res.idx  = r[IDX_W-1:0];
		if (r[PW-1]) begin
			res.clip = 1'b1;
			res.idx  = '0;
		end else if (r > last) begin
			res.clip = 1'b1;
			res.idx  = last[IDX_W-1:0];
		end
		pix_map = res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= 16'sd10240;
			coef_b_q    <= 16'sd768;
			coef_c_q    <= 16'sd7168;
			step_size_q <= 16'd328;
			x_scale_q   <= 16'd4424;
			y_scale_q   <= 16'd829;
			x_min_q     <= -16'sd50;
			y_min_q     <= -16'sd150;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_A:    coef_a_q    <= cfg_data;
				REG_COEF_B:    coef_b_q    <= cfg_data;
				REG_COEF_C:    coef_c_q    <= cfg_data;
				REG_STEP_SIZE: step_size_q <= cfg_data;
				REG_X_SCALE:   x_scale_q   <= cfg_data;
				REG_Y_SCALE:   y_scale_q   <= cfg_data;
				REG_X_MIN:     x_min_q     <= cfg_data;
				REG_Y_MIN:     y_min_q     <= cfg_data;
			endcase
		end
	end

	assign d_yx      = XW'(point_y_q) - XW'(point_x_q);
	assign c_minus_a = CW'(coef_c_q) - CW'(coef_a_q);
	assign x_off     = DIFF_W'(point_x_q) - (DIFF_W'(x_min_q) <<< FRAC_BITS);
	assign y_off     = DIFF_W'(point_y_q) - (DIFF_W'(y_min_q) <<< FRAC_BITS);

	always_comb begin
		case (dp_cmd.mul_sel)
			MS_HY:   br_pick = by_q;
			MS_HZ:   br_pick = bz_q;
			default: br_pick = bx_q;
		endcase
	end

	assign br_sat = sat_br(br_pick);
	assign mul_en = (dp_cmd.mul_sel != MS_HOLD);

	always_comb begin
		m0_a = '0;
		m0_b = '0;
		m1_a = '0;
		m1_b = '0;
		case (dp_cmd.mul_sel)
			MS_BR1: begin
				m0_a = MA_W'(d_yx);
				m0_b = MB_W'(coef_a_q);
				m1_a = MA_W'(point_x_q);
				m1_b = MB_W'(c_minus_a);
			end
			MS_BR2: begin
				m0_a = MA_W'(point_x_q);
				m0_b = MB_W'(point_z_q);
				m1_a = MA_W'(point_y_q);
				m1_b = MB_W'(coef_c_q);
			end
			MS_BR3: begin
				m0_a = MA_W'(point_x_q);
				m0_b = MB_W'(point_y_q);
				m1_a = MA_W'(point_z_q);
				m1_b = MB_W'(coef_b_q);
			end
			MS_HX, MS_HY, MS_HZ: begin
				m0_a = MA_W'($signed(br_sat[BR_W-1:STEP_FRAC]));
				m0_b = MB_W'(step_size_q);
				m1_a = MA_W'(br_sat[STEP_FRAC-1:0]);
				m1_b = MB_W'(step_size_q);
			end
			MS_PIX: begin
				m0_a = x_off;
				m0_b = MB_W'(x_scale_q);
				m1_a = y_off;
				m1_b = MB_W'(y_scale_q);
			end
			default: begin
				m0_a = '0;
			end
		endcase
	end

	cae_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul0 (
		.clk     (clk),
		.en      (mul_en),
		.a       (m0_a),
		.b       (m0_b),
		.prod_s1 (p0)
	);

	cae_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul1 (
		.clk     (clk),
		.en      (mul_en),
		.a       (m1_a),
		.b       (m1_b),
		.prod_s1 (p1)
	);

	assign p0_rc_w = (p0 + HALF_C) >>> COEF_FRAC;
	assign p0_rp_w = (p0 + HALF_P) >>> FRAC_BITS;
	assign p1_rc_w = (p1 + HALF_C) >>> COEF_FRAC;
	assign p0_rc   = p0_rc_w[ACC_W-1:0];
	assign p0_rp   = p0_rp_w[ACC_W-1:0];
	assign p1_rc   = p1_rc_w[ACC_W-1:0];

	// The bracket times h arrives as a high part and a low part whose
	// rounding only touches the low product.
	assign frac_sum = p1[FS_W-1:0] + FS_HALF;
	assign frac_ext = SUM_W'(frac_sum[FS_W-1:STEP_FRAC]);

	always_comb begin
		case (dp_cmd.upd_sel)
			US_X:    pos_old = point_x_q;
			US_Y:    pos_old = point_y_q;
			default: pos_old = point_z_q;
		endcase
	end

	assign new_sum = SUM_W'(pos_old) + SUM_W'(p0) + frac_ext;

	always_comb begin
		if (new_sum > P_MAX) begin
			pos_new = P_MAX[POS_W-1:0];
		end else if (new_sum < P_MIN) begin
			pos_new = P_MIN[POS_W-1:0];
		end else begin
			pos_new = new_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.upd_sel)
			US_BR2: begin
				bx_q <= p0_rc;
				by_q <= p1_rc;
			end
			US_BR3: by_q <= by_q - p0_rp + p1_rc;
			US_BR4: bz_q <= p0_rp - p1_rc;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= POS_INIT;
			point_y_q <= POS_INIT;
			point_z_q <= POS_INIT;
		end else if (dp_cmd.load_point) begin
			point_x_q <= load_x;
			point_y_q <= load_y;
			point_z_q <= load_z;
		end else begin
			case (dp_cmd.upd_sel)
				US_X:    point_x_q <= pos_new;
				US_Y:    point_y_q <= pos_new;
				US_Z:    point_z_q <= pos_new;
				default: ;
			endcase
		end
	end

	assign pix_x = pix_map(p0, X_LAST);
	assign pix_y = pix_map(p1, Y_LAST);

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			pos_x_q   <= point_x_q;
			pos_y_q   <= point_y_q;
			pos_z_q   <= point_z_q;
			x_index_q <= pix_x.idx;
			y_index_q <= pix_y.idx;
			clipped_q <= pix_x.clip | pix_y.clip;
		end
	end

	assign pos_x   = pos_x_q;
	assign pos_y   = pos_y_q;
	assign pos_z   = pos_z_q;
	assign x_index = x_index_q;
	assign y_index = y_index_q;
	assign clipped = clipped_q;

endmodule

FILE: hw/rtl/cae_ctrl.sv
module cae_ctrl import cae_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  logic    cmd,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t dp_cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_BR1  = 10'b00_0000_0010,
		ST_BR2  = 10'b00_0000_0100,
		ST_BR3  = 10'b00_0000_1000,
		ST_BR4  = 10'b00_0001_0000,
		ST_UX   = 10'b00_0010_0000,
		ST_UY   = 10'b00_0100_0000,
		ST_UZ   = 10'b00_1000_0000,
		ST_PIX  = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '{load_point: 1'b0, mul_sel: MS_HOLD, upd_sel: US_NONE, out_load: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (cmd) begin
						dp_cmd.load_point = 1'b1;
						state_d = ST_PIX;
					end else begin
						state_d = ST_BR1;
					end
				end
			end
			ST_BR1: begin
				dp_cmd.mul_sel = MS_BR1;
				state_d = ST_BR2;
			end
			ST_BR2: begin
				dp_cmd.mul_sel = MS_BR2;
				dp_cmd.upd_sel = US_BR2;
				state_d = ST_BR3;
			end
			ST_BR3: begin
				dp_cmd.mul_sel = MS_BR3;
				dp_cmd.upd_sel = US_BR3;
				state_d = ST_BR4;
			end
			ST_BR4: begin
				dp_cmd.mul_sel = MS_HX;
				dp_cmd.upd_sel = US_BR4;
				state_d = ST_UX;
			end
			ST_UX: begin
				dp_cmd.mul_sel = MS_HY;
				dp_cmd.upd_sel = US_X;
				state_d = ST_UY;
			end
			ST_UY: begin
				dp_cmd.mul_sel = MS_HZ;
				dp_cmd.upd_sel = US_Y;
				state_d = ST_UZ;
			end
			ST_UZ: begin
				dp_cmd.upd_sel = US_Z;
				state_d = ST_PIX;
			end
			ST_PIX: begin
				dp_cmd.mul_sel = MS_PIX;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					dp_cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != ST_IDLE))
		else $error("Sequencer stayed idle after taking an item.");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("Result register overwritten before it was taken.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_valid_q && !rsp_ready)
		|=> (state_q == ST_DONE && rsp_valid_q))
		else $error("Finished result not held while the output stalls.");

endmodule

FILE: tb/sv/attractor_point_checker.sv
`timescale 1ns / 100ps
module attractor_point_checker import cae_pkg::*; #(
	parameter int PALETTE_WIDTH  = 1920,
	parameter int PALETTE_HEIGHT = 1080,
	parameter int FRAC_BITS      = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_ready,
	input  logic                    cmd,
	input  logic signed [POS_W-1:0] load_x,
	input  logic signed [POS_W-1:0] load_y,
	input  logic signed [POS_W-1:0] load_z,
	input  logic                    rsp_valid,
	input  logic                    rsp_ready,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [IDX_W-1:0]        x_index,
	input  logic [IDX_W-1:0]        y_index,
	input  logic                    clipped,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data,
	output int                      fail_count,
	output int                      pending,
	output int                      checked
);

	localparam longint BRACKET_MAX = (longint'(1) <<< (BR_W - 1)) - 1;
	localparam longint BRACKET_MIN = -BRACKET_MAX - 1;
	localparam longint POS_MAX     = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint POS_MIN     = -POS_MAX - 1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [IDX_W-1:0]        col;
		logic [IDX_W-1:0]        row;
		logic                    clip;
	} plotted_point_t;

	logic [REG_W-1:0]        regs [8];
	logic signed [POS_W-1:0] cur_x, cur_y, cur_z;
	plotted_point_t          expected_points [$];

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic signed [POS_W-1:0] euler_advance(logic signed [POS_W-1:0] p,
			longint bracket, longint h);
		longint d;
		d = round_shift(clamp(bracket, BRACKET_MIN, BRACKET_MAX) * h, STEP_FRAC);
		return POS_W'(clamp(longint'(p) + d, POS_MIN, POS_MAX));
	endfunction

	function automatic logic [IDX_W-1:0] pixel_index(logic signed [POS_W-1:0] p,
			logic [REG_W-1:0] min_reg, logic [REG_W-1:0] scale_reg, longint limit,
			inout logic clip);
		longint mn, sc, v, r;
		mn = longint'($signed(min_reg));
		sc = longint'(scale_reg);
		v = (longint'(p) - mn * (longint'(1) <<< FRAC_BITS)) * sc;
		if (v >= 0)
			r = round_shift(v, FRAC_BITS + COEF_FRAC);
		else
			r = -round_shift(-v, FRAC_BITS + COEF_FRAC);
		if (r < 0) begin
			clip = 1'b1;
			r = 0;
		end
		if (r > limit - 1) begin
			clip = 1'b1;
			r = limit - 1;
		end
		return IDX_W'(r);
	endfunction

	task automatic predict_point(logic op, logic signed [POS_W-1:0] lx,
			logic signed [POS_W-1:0] ly, logic signed [POS_W-1:0] lz);
		longint a, b, c, h, x, y, z, bx, by, bz;
		plotted_point_t e;
		logic clip;
		if (op) begin
			cur_x = lx;
			cur_y = ly;
			cur_z = lz;
		end else begin
			a = longint'($signed(regs[REG_COEF_A]));
			b = longint'($signed(regs[REG_COEF_B]));
			c = longint'($signed(regs[REG_COEF_C]));
			h = longint'(regs[REG_STEP_SIZE]);
			x = longint'(cur_x);
			y = longint'(cur_y);
			z = longint'(cur_z);
			bx = round_shift(a * (y - x), COEF_FRAC);
			by = round_shift((c - a) * x, COEF_FRAC) - round_shift(x * z, FRAC_BITS)
				+ round_shift(c * y, COEF_FRAC);
			bz = round_shift(x * y, FRAC_BITS) - round_shift(b * z, COEF_FRAC);
			cur_x = euler_advance(cur_x, bx, h);
			cur_y = euler_advance(cur_y, by, h);
			cur_z = euler_advance(cur_z, bz, h);
		end
		clip = 1'b0;
		e.x = cur_x;
		e.y = cur_y;
		e.z = cur_z;
		e.col = pixel_index(cur_x, regs[REG_X_MIN], regs[REG_X_SCALE],
			longint'(PALETTE_WIDTH), clip);
		e.row = pixel_index(cur_y, regs[REG_Y_MIN], regs[REG_Y_SCALE],
			longint'(PALETTE_HEIGHT), clip);
		e.clip = clip;
		expected_points.push_back(e);
	endtask

	task automatic compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s of result %0d is %h, expected %h", $realtime, name, checked,
					got, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		plotted_point_t e;
		if (!arst_n) begin
			regs[REG_COEF_A]    = REG_W'(10240);
			regs[REG_COEF_B]    = REG_W'(768);
			regs[REG_COEF_C]    = REG_W'(7168);
			regs[REG_STEP_SIZE] = REG_W'(328);
			regs[REG_X_SCALE]   = REG_W'(4424);
			regs[REG_Y_SCALE]   = REG_W'(829);
			regs[REG_X_MIN]     = REG_W'(-50);
			regs[REG_Y_MIN]     = REG_W'(-150);
			cur_x = POS_W'(1) << (FRAC_BITS - 1);
			cur_y = POS_W'(1) << (FRAC_BITS - 1);
			cur_z = POS_W'(1) << (FRAC_BITS - 1);
			expected_points.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we)
				regs[cfg_index] = cfg_data;
			if (rsp_valid && rsp_ready) begin
				if (expected_points.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result arrived with no item outstanding", $realtime);
				end else begin
					e = expected_points.pop_front();
					compare_field("pos_x", e.x, pos_x);
					compare_field("pos_y", e.y, pos_y);
					compare_field("pos_z", e.z, pos_z);
					compare_field("x_index", POS_W'(e.col), POS_W'(x_index));
					compare_field("y_index", POS_W'(e.row), POS_W'(y_index));
					compare_field("clipped", POS_W'(e.clip), POS_W'(clipped));
					checked++;
				end
			end
			if (req_valid && req_ready)
				predict_point(cmd, load_x, load_y, load_z);
			pending = expected_points.size();
		end
	end

endmodule

FILE: tb/sv/chaotic_attractor_euler_plot_test.sv
`timescale 1ns / 100ps
module chaotic_attractor_euler_plot_test;
	import cae_pkg::*;

	localparam int   CYCLE_LIMIT = 600000;
	localparam logic OP_STEP     = 1'b0;
	localparam logic OP_LOAD     = 1'b1;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_ready;
	logic                    cmd;
	logic signed [POS_W-1:0] load_x, load_y, load_z;
	logic                    rsp_valid;
	logic                    rsp_ready;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [IDX_W-1:0]        x_index, y_index;
	logic                    clipped;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]        cfg_data;

	int fail_count, pending, checked;
	int cycle_count, loads_sent, steps_sent, settings_used, rsp_stall;
	bit quiet;

	chaotic_attractor_euler_plot u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.load_x    (load_x),
		.load_y    (load_y),
		.load_z    (load_z),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.x_index   (x_index),
		.y_index   (y_index),
		.clipped   (clipped),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	attractor_point_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_z     (load_z),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.x_index    (x_index),
		.y_index    (y_index),
		.clipped    (clipped),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [POS_W-1:0] near_coord(int lo, int hi);
		int v;
		v = int'($urandom_range(0, (hi - lo) * 65536)) + lo * 65536;
		return v;
	endfunction

	task automatic send_item(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic [POS_W-1:0] z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		cmd = op;
		load_x = x;
		load_y = y;
		load_z = z;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		if (op == OP_LOAD)
			loads_sent++;
		else
			steps_sent++;
	endtask

	task automatic step_point();
		send_item(OP_STEP, $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_regs(logic [REG_W-1:0] a, logic [REG_W-1:0] b,
			logic [REG_W-1:0] c, logic [REG_W-1:0] h, logic [REG_W-1:0] xs,
			logic [REG_W-1:0] ys, logic [REG_W-1:0] xm, logic [REG_W-1:0] ym);
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_STEP_SIZE, h);
		write_reg(REG_X_SCALE, xs);
		write_reg(REG_Y_SCALE, ys);
		write_reg(REG_X_MIN, xm);
		write_reg(REG_Y_MIN, ym);
		settings_used++;
	endtask

	task automatic run_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 2 && pending != 0) begin
				req_valid = 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			if (r < 8)
				send_item(OP_LOAD, $urandom, $urandom, $urandom);
			else if (r < 14)
				send_item(OP_LOAD, near_coord(-30, 30), near_coord(-40, 40), near_coord(0, 60));
			else
				step_point();
		end
		quiet = 1'b0;
		drain();
	endtask

	initial begin
		rsp_ready = 1'b0;
		rsp_stall = 0;
		forever begin
			@(negedge clk);
			if (rsp_stall > 0) begin
				rsp_ready = 1'b0;
				rsp_stall--;
			end else begin
				rsp_ready = 1'b1;
				rsp_stall = pick_gap();
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = OP_STEP;
		load_x = '0;
		load_y = '0;
		load_z = '0;
		cfg_we = 1'b0;
		cfg_index = REG_COEF_A;
		cfg_data = '0;
		quiet = 1'b0;
		loads_sent = 0;
		steps_sent = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		repeat (3) step_point();
		send_item(OP_LOAD, 32'h0, 32'h0, 32'h0);
		step_point();
		send_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		step_point();
		send_item(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		step_point();
		send_item(OP_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 32'(-50 * 65536 - 1), 32'(10 * 65536), 32'(20 * 65536));
		send_item(OP_LOAD, 32'(100 * 65536), 32'(10 * 65536), 32'(20 * 65536));
		send_item(OP_LOAD, 32'(5 * 65536), 32'(200 * 65536), 32'(20 * 65536));
		send_item(OP_LOAD, 32'(65536), 32'(2 * 65536), 32'(20 * 65536));
		repeat (3) step_point();
		drain();

		// A unit x scale and a half y scale with zero offsets put exact halves on the rounding boundary.
		program_regs(10240, 768, 7168, 328, 256, 128, 0, 0);
		send_item(OP_LOAD, 32'(5 * 65536 + 32768), 32'(3 * 65536), 32'h0);
		send_item(OP_LOAD, 32'(-5 * 65536 - 32768), 32'(-3 * 65536), 32'h0);
		send_item(OP_LOAD, 32'(1919 * 65536 + 32768), 32'(2158 * 65536), 32'h0);
		drain();

		program_regs(10240, 768, 7168, 328, 4424, 829, -50, -150);
		run_phase(300);
		program_regs(32767, 32767, 32767, 65535, 65535, 65535, 32767, 32767);
		run_phase(200);
		program_regs(-32768, -32768, -32768, 0, 0, 0, -32768, -32768);
		run_phase(200);
		program_regs(35 * 256, 3 * 256, 28 * 256, 1311, REG_W'($urandom_range(256, 8192)),
			REG_W'($urandom_range(256, 2048)), -30, -40);
		run_phase(200);
		program_regs(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
			REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
		run_phase(200);
		program_regs(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
			REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
		run_phase(200);
		program_regs(10240, 768, 7168, 2000, 4424, 829, -50, -150);
		run_phase(200);

		$display("Covered %0d Euler steps and %0d point loads under %0d register settings,",
			steps_sent, loads_sent, settings_used);
		$display("with %0d results compared against the predicted point and pixel.", checked);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: chaotic_attractor_euler_plot.f
hw/rtl/cae_pkg.sv
hw/rtl/cae_mul.sv
hw/rtl/cae_dp.sv
hw/rtl/cae_ctrl.sv
hw/rtl/chaotic_attractor_euler_plot.sv
tb/sv/attractor_point_checker.sv
tb/sv/chaotic_attractor_euler_plot_test.sv
